@@ rtl/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  localparam int LENGTH_REG_W = 7;
  localparam int OFFSET_W     = 32;
  localparam int COUNT_W      = 8;
  localparam int INDEX_W      = 6;
  localparam int BYTE_W       = 8;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 48;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 32;

  // request kinds carried on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET   = 1'b1;

  // control broadcast to every cell of the ring
  typedef struct packed {
    logic              scan;      // shift the window, new byte at the tail
    logic              rot_up;    // rotate, cell j takes cell j+1
    logic              rot_down;  // rotate, cell j takes cell j-1
    logic [BYTE_W-1:0] data;
    logic              load;      // write one pattern entry
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0] value;
    logic              wild;
  } ring_ctrl_t;

  typedef struct packed {
    logic b_last_pend;  // last scan byte under evaluation
    logic c_full;       // finished result waiting for the output register
  } tally_status_t;

endpackage

`default_nettype wire

@@ rtl/wbps_cell.sv @@
// ----------------------------------------------------------------------------
// wbps_cell
// One ring cell: holds a pattern entry and the window byte aligned to it.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int IDX         = 0
) (
  input  wire logic                              clk,
  input  wire ring_ctrl_t                        ctrl,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]  align,
  input  wire logic [BYTE_W-1:0]                 up_byte,
  input  wire logic [BYTE_W-1:0]                 down_byte,
  output logic      [BYTE_W-1:0]                 win_byte,
  output logic                                   ok
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [BYTE_W-1:0] pat_byte;
  logic              pat_wild;
  logic              tail;
  logic              active;
  logic              load_hit;

  assign tail     = (align == LEN_W'(IDX + 1));
  assign active   = (LEN_W'(IDX) < align);
  assign load_hit = ctrl.load && (int'(ctrl.index) == IDX);

  always_ff @(posedge clk) begin
    if (load_hit) begin
      pat_byte <= ctrl.value;
      pat_wild <= ctrl.wild;
    end
    if (ctrl.scan) begin
      win_byte <= tail ? ctrl.data : up_byte;
    end else if (ctrl.rot_up) begin
      win_byte <= up_byte;
    end else if (ctrl.rot_down) begin
      win_byte <= down_byte;
    end
  end

  assign ok = !active || pat_wild || (pat_byte == win_byte);

endmodule

`default_nettype wire

@@ rtl/wbps_tally.sv @@
// ----------------------------------------------------------------------------
// wbps_tally
// Match counting, region bookkeeping and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_tally
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              scan_req,
  input  wire logic                              last_req,
  input  wire logic                              hit,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]  align,
  input  wire logic [OFFSET_W-1:0]               start_offset,
  input  wire logic                              m_tready,
  output logic                                   m_tvalid,
  output logic      [OUT_DATA_W-1:0]             m_tdata,
  output tally_status_t                          status
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic                b_valid;
  logic                b_last;
  logic [LEN_W-1:0]    fill;
  logic [OFFSET_W-1:0] bytes_seen;
  logic [COUNT_W-1:0]  count;
  logic [OFFSET_W-1:0] last_start;

  logic                c_valid;
  logic [COUNT_W-1:0]  c_count;
  logic [OFFSET_W-1:0] c_start;

  logic                out_valid;
  logic [OFFSET_W-1:0] out_offset;
  logic                out_unique;
  logic [COUNT_W-1:0]  out_count;

  logic [LEN_W-1:0]    fill_next;
  logic [OFFSET_W-1:0] seen_next;
  logic                win_hit;
  logic [COUNT_W-1:0]  count_next;
  logic [OFFSET_W-1:0] start_next;
  logic                c_pop;

  always_comb begin
    fill_next  = (fill < LEN_W'(MAX_PATTERN)) ? fill + LEN_W'(1) : fill;
    seen_next  = bytes_seen + OFFSET_W'(1);
    win_hit    = hit && (fill_next >= align);
    count_next = (win_hit && (count != {COUNT_W{1'b1}})) ? count + COUNT_W'(1) : count;
    start_next = win_hit ? seen_next - OFFSET_W'(align) : last_start;
  end

  assign c_pop = c_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      b_last     <= 1'b0;
      fill       <= '0;
      bytes_seen <= '0;
      count      <= '0;
      last_start <= '0;
      c_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      b_valid <= scan_req;
      b_last  <= scan_req && last_req;

      if (b_valid) begin
        if (b_last) begin
          // region done: hand off and clear for the next one
          c_count    <= count_next;
          c_start    <= start_next;
          fill       <= '0;
          bytes_seen <= '0;
          count      <= '0;
          last_start <= '0;
        end else begin
          fill       <= fill_next;
          bytes_seen <= seen_next;
          count      <= count_next;
          last_start <= start_next;
        end
      end

      if (b_valid && b_last) begin
        c_valid <= 1'b1;
      end else if (c_pop) begin
        c_valid <= 1'b0;
      end

      if (c_pop) begin
        out_valid  <= 1'b1;
        out_count  <= c_count;
        out_unique <= (c_count == COUNT_W'(1));
        out_offset <= (c_count == COUNT_W'(1)) ? start_offset + c_start : '0;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - OFFSET_W - 1 - COUNT_W){1'b0}},
                     out_count, out_unique, out_offset};

  assign status.b_last_pend = b_valid && b_last;
  assign status.c_full      = c_valid;

endmodule

`default_nettype wire

@@ rtl/wildcard_byte_pattern_scanner_core.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// Wildcard byte signature search over a byte stream, built on a ring of cells.
// ----------------------------------------------------------------------------
// Throughput: one load or scan request per cycle while s_axis_tready is high; a scan
//   byte shifts the cell ring once, and the compare of all cells plus the tally takes
//   the next cycle. A region's last byte passes evaluation, staging and output registers;
//   input stalls after that byte until staging empties, longer while m_axis_tready is low.
// A pattern_length write rotates the ring one cell a cycle; input stalls until aligned.
// Reset (rst, synchronous): counters clear, pattern_length 1, start_offset 0.
`default_nettype none

module wildcard_byte_pattern_scanner_core
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [5:0] entry_index, [13:6] entry_value, [14] entry_wild, [22:15] data_byte
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
  // [0] cmd
  input  wire logic                   s_axis_tuser,
  input  wire logic                   s_axis_tlast,
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [31:0] match_offset, [32] unique_match, [40:33] match_count
  output logic      [OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LENGTH_REG_W-1:0] pattern_length;
  logic [OFFSET_W-1:0]     start_offset;
  logic [LEN_W-1:0]        used_len;
  logic [LEN_W-1:0]        align;
  logic                    aligned;
  logic                    accept;
  ring_ctrl_t              ctrl;
  logic [BYTE_W-1:0]       win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  ok;
  logic                    hit;
  tally_status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LENGTH_REG_W'(1);
      start_offset   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LENGTH_REG_W-1:0];
        REG_START_OFFSET:   start_offset   <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the length register to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      used_len = LEN_W'(1);
    end else if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
      used_len = LEN_W'(MAX_PATTERN);
    end else begin
      used_len = LEN_W'(pattern_length);
    end
  end

  assign aligned = (align == used_len);

  // align tracks the length the ring is laid out for; step it one cell a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      align <= LEN_W'(1);
    end else if (align > used_len) begin
      align <= align - LEN_W'(1);
    end else if (align < used_len) begin
      align <= align + LEN_W'(1);
    end
  end

  assign s_axis_tready = aligned && !status.b_last_pend && !status.c_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl.scan     = accept && (s_axis_tuser == CMD_SCAN);
    ctrl.load     = accept && (s_axis_tuser == CMD_LOAD);
    ctrl.rot_up   = align > used_len;
    ctrl.rot_down = align < used_len;
    ctrl.data     = s_axis_tdata[22:15];
    ctrl.index    = s_axis_tdata[5:0];
    ctrl.value    = s_axis_tdata[13:6];
    ctrl.wild     = s_axis_tdata[14];
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    wbps_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .IDX         (j)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .align     (align),
      .up_byte   (win[(j + 1) % MAX_PATTERN]),
      .down_byte (win[(j + MAX_PATTERN - 1) % MAX_PATTERN]),
      .win_byte  (win[j]),
      .ok        (ok[j])
    );
  end

  assign hit = &ok;

  wbps_tally #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_tally (
    .clk          (clk),
    .rst          (rst),
    .scan_req     (ctrl.scan),
    .last_req     (s_axis_tlast),
    .hit          (hit),
    .align        (align),
    .start_offset (start_offset),
    .m_tready     (m_axis_tready),
    .m_tvalid     (m_axis_tvalid),
    .m_tdata      (m_axis_tdata),
    .status       (status)
  );

  a_last_reaches_eval: assert property (@(posedge clk) disable iff (rst)
    (ctrl.scan && s_axis_tlast) |=> status.b_last_pend)
    else $error("last scan byte not taken into evaluation");

  a_eval_to_stage: assert property (@(posedge clk) disable iff (rst)
    status.b_last_pend |=> status.c_full)
    else $error("finished region result was not staged");

  a_unique_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[40:33] == 8'd1)))
    else $error("unique flag disagrees with match count");

  a_ring_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.scan, ctrl.rot_up, ctrl.rot_down}))
    else $error("scan shift collides with ring rotation");

endmodule

`default_nettype wire

@@ test/wbps_checker.sv @@
// ----------------------------------------------------------------------------
// wbps_checker
// Watches the request, result and configuration ports of the scanner, keeps
// its own copy of signature, byte window and tallies, and compares every
// result with the report predicted for the region it closes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wbps_checker
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                   s_axis_tuser,
  input  wire logic                   s_axis_tlast,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output int                          errors,
  output int                          pending,
  output int                          reports,
  output int                          single_hits,
  output int                          saturated
);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                unique_hit;
    logic [COUNT_W-1:0]  count;
  } scan_report_t;

  logic [BYTE_W-1:0]       sig_byte [MAX_PATTERN];
  logic                    sig_wild [MAX_PATTERN];
  logic [BYTE_W-1:0]       window [MAX_PATTERN];   // index 0 holds the newest byte
  logic [OFFSET_W-1:0]     bytes_seen;
  logic [OFFSET_W-1:0]     last_start;
  logic [OFFSET_W-1:0]     base_offset;
  logic [LENGTH_REG_W-1:0] length_reg;
  int                      hits;
  int                      fill;
  scan_report_t            expected_reports[$];
  int                      err_cnt;
  int                      rep_cnt;
  int                      uniq_cnt;
  int                      sat_cnt;

  // Out-of-range register values clamp to 1 and MAX_PATTERN.
  function automatic int active_length();
    if (length_reg == 0) return 1;
    if (int'(length_reg) > MAX_PATTERN) return MAX_PATTERN;
    return int'(length_reg);
  endfunction

  // Entry j faces the j-th byte of the window, counted from its oldest byte.
  function automatic bit window_hit(int len);
    for (int j = 0; j < len; j++) begin
      if (!sig_wild[j] && sig_byte[j] !== window[len - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    for (int i = 0; i < MAX_PATTERN; i++) window[i] = '0;
    bytes_seen = '0;
    last_start = '0;
    hits       = 0;
    fill       = 0;
  endtask

  task automatic take_request(logic cmd, logic [IN_DATA_W-1:0] payload, logic last);
    logic [INDEX_W-1:0] idx;
    int                 len;
    scan_report_t       rep;
    idx = payload[5:0];
    if (cmd == CMD_LOAD) begin
      if (int'(idx) < MAX_PATTERN) begin
        sig_byte[idx] = payload[13:6];
        sig_wild[idx] = payload[14];
      end
      return;
    end
    for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i - 1];
    window[0]  = payload[22:15];
    bytes_seen = bytes_seen + 1;
    if (fill < MAX_PATTERN) fill++;
    len = active_length();
    if (fill >= len && window_hit(len)) begin
      if (hits < 255) hits++;
      last_start = bytes_seen - OFFSET_W'(len);
    end
    if (!last) return;
    rep.count      = COUNT_W'(hits);
    rep.unique_hit = (hits == 1);
    rep.offset     = (hits == 1) ? base_offset + last_start : '0;
    expected_reports.insert(expected_reports.size(), rep);
    clear_scan();
  endtask

  task automatic check_report(logic [OUT_DATA_W-1:0] raw);
    scan_report_t got;
    scan_report_t exp_rep;
    got.offset     = raw[31:0];
    got.unique_hit = raw[32];
    got.count      = raw[40:33];
    if (expected_reports.size() == 0) begin
      if (err_cnt < 10)
        $display("%0t: report with none outstanding: offset %h unique %0d count %0d",
                 $realtime, got.offset, got.unique_hit, got.count);
      err_cnt++;
      return;
    end
    exp_rep = expected_reports.pop_front();
    rep_cnt++;
    if (exp_rep.unique_hit) uniq_cnt++;
    if (exp_rep.count == 8'hFF) sat_cnt++;
    if (got.offset !== exp_rep.offset || got.unique_hit !== exp_rep.unique_hit ||
        got.count !== exp_rep.count) begin
      if (err_cnt < 10) begin
        $display("%0t: report %0d mismatch: expected offset %h unique %0d count %0d",
                 $realtime, rep_cnt, exp_rep.offset, exp_rep.unique_hit, exp_rep.count);
        $display("%0t: report %0d mismatch: actual   offset %h unique %0d count %0d",
                 $realtime, rep_cnt, got.offset, got.unique_hit, got.count);
      end
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        sig_byte[i] = '0;
        sig_wild[i] = 1'b0;
      end
      clear_scan();
      length_reg  = LENGTH_REG_W'(1);
      base_offset = '0;
      expected_reports.delete();
      err_cnt  = 0;
      rep_cnt  = 0;
      uniq_cnt = 0;
      sat_cnt  = 0;
    end else begin
      // results leave only after the last byte of their region, so drain before taking
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) take_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      if (cfg_we) begin
        if (cfg_index == REG_PATTERN_LENGTH) length_reg = cfg_data[LENGTH_REG_W-1:0];
        else if (cfg_index == REG_START_OFFSET) base_offset = cfg_data;
      end
    end
    errors      <= err_cnt;
    pending     <= expected_reports.size();
    reports     <= rep_cnt;
    single_hits <= uniq_cnt;
    saturated   <= sat_cnt;
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives load and scan requests into the wildcard byte pattern scanner: a
// directed opening over the field extremes and corner cases, then phases of
// random signatures, lengths and offsets with planted matches, noise loads
// and mid-region length changes, under random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import wbps_pkg::*;

  localparam int MAX_PATTERN   = MAX_PATTERN_DEF;
  localparam int SETTLE_CYCLES = MAX_PATTERN + 8;
  localparam int ITEM_TARGET   = 1100;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  int errors;
  int pending;
  int reports;
  int single_hits;
  int saturated;

  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int          items_sent = 0;
  int          loads_sent = 0;
  int          scans_sent = 0;
  int          cur_len = 1;
  bit          loaded [MAX_PATTERN];
  logic [7:0]  pat_val [MAX_PATTERN];
  bit          pat_wild [MAX_PATTERN];

  wildcard_byte_pattern_scanner_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wbps_checker #(
    .MAX_PATTERN(MAX_PATTERN)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending),
    .reports       (reports),
    .single_hits   (single_hits),
    .saturated     (saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure bursts
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int effective_length(logic [LENGTH_REG_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_PATTERN) return MAX_PATTERN;
    return int'(v);
  endfunction

  task automatic send_item(logic cmd, logic [5:0] idx, logic [7:0] val, logic wild,
                           logic [7:0] data, logic last);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, data, wild, val, idx};
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_entry(int idx, logic [7:0] val, logic wild, logic last);
    send_item(CMD_LOAD, idx[5:0], val, wild, 8'($urandom), last);
    loaded[idx]   = 1'b1;
    pat_val[idx]  = val;
    pat_wild[idx] = wild;
    loads_sent++;
  endtask

  // idx, value and wild ride along as junk on scan requests
  task automatic scan_byte(logic [7:0] data, logic last);
    send_item(CMD_SCAN, 6'($urandom), 8'($urandom), 1'($urandom), data, last);
    scans_sent++;
  endtask

  // Hold requests until every report is back and the ring has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (index == REG_PATTERN_LENGTH) cur_len = effective_length(value[LENGTH_REG_W-1:0]);
  endtask

  // never compare against an entry that was not loaded
  task automatic fill_entries(int n);
    for (int i = 0; i < n; i++) begin
      if (!loaded[i]) load_entry(i, 8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
    end
  endtask

  task automatic set_length(logic [LENGTH_REG_W-1:0] v);
    fill_entries(effective_length(v));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(v));
  endtask

  task automatic scan_region(int n, int plants, bit narrow, bit shift_len);
    logic [7:0] bytes[$];
    int         p;
    for (int i = 0; i < n; i++)
      bytes.insert(i, narrow ? 8'($urandom_range(0, 3)) : 8'($urandom));
    // plant copies of the signature so windows actually hit
    for (int k = 0; k < plants; k++) begin
      if (n >= cur_len) begin
        p = $urandom_range(0, n - cur_len);
        for (int j = 0; j < cur_len; j++)
          bytes[p + j] = pat_wild[j] ? 8'($urandom) : pat_val[j];
      end
    end
    for (int i = 0; i < n; i++) begin
      if (shift_len && i == n / 2 && i > 0)
        set_length(LENGTH_REG_W'($urandom_range(1, 6)));
      if ($urandom_range(0, 24) == 0)
        load_entry($urandom_range(0, MAX_PATTERN - 1), 8'($urandom), 1'($urandom),
                   1'($urandom));
      scan_byte(bytes[i], i == n - 1);
    end
  endtask

  initial begin
    logic [LENGTH_REG_W-1:0] len_code;
    logic [CFG_DATA_W-1:0]   offs;
    int                      phase_no;
    int                      nreg;
    int                      r;
    bit                      calm;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, load with last set, offset wrap,
    // short region, wildcard hit, length change inside a region
    load_entry(0, 8'hFF, 1'b0, 1'b1);
    scan_byte(8'h00, 1'b1);
    scan_byte(8'hFF, 1'b1);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hFF, 1'b1);
    write_reg(REG_START_OFFSET, 32'hFFFF_FFFF);
    set_length('0);
    scan_byte(8'h12, 1'b0);
    scan_byte(8'hFF, 1'b1);
    load_entry(63, 8'h00, 1'b1, 1'b0);
    load_entry(0, 8'hAB, 1'b0, 1'b0);
    load_entry(1, 8'h00, 1'b1, 1'b1);
    load_entry(2, 8'hCD, 1'b0, 1'b0);
    set_length(7'd3);
    write_reg(REG_START_OFFSET, 32'h0000_1000);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'hCD, 1'b1);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'h5A, 1'b0);
    scan_byte(8'hCD, 1'b1);
    scan_byte(8'hAB, 1'b0);
    scan_byte(8'h77, 1'b0);
    set_length(7'd1);
    scan_byte(8'hAB, 1'b1);
    load_entry(5, 8'h80, 1'b0, 1'b1);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      calm       = items_sent >= ITEM_TARGET - 150;
      tx_idle_on = !calm && $urandom_range(0, 3) != 0;
      rx_idle_on = !calm && $urandom_range(0, 3) != 0;

      r = $urandom_range(0, 19);
      if (r == 0)      len_code = '0;
      else if (r == 1) len_code = 7'd127;
      else if (r == 2) len_code = 7'd64;
      else if (r < 8)  len_code = LENGTH_REG_W'($urandom_range(5, 20));
      else             len_code = LENGTH_REG_W'($urandom_range(1, 4));
      if (phase_no == 2) len_code = 7'd1;

      r = $urandom_range(0, 3);
      if (r == 0)      offs = '0;
      else if (r == 1) offs = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else if (r == 2) offs = $urandom;
      else             offs = $urandom_range(0, 1000);

      if ($urandom_range(0, 1)) begin
        write_reg(REG_START_OFFSET, offs);
        set_length(len_code);
      end else begin
        set_length(len_code);
        write_reg(REG_START_OFFSET, offs);
      end

      if (phase_no == 2) begin
        // all-wild single entry: every byte hits, drive the tally into saturation
        load_entry(0, 8'($urandom), 1'b1, 1'($urandom));
        scan_region(270, 0, 1'b0, 1'b0);
      end else begin
        for (int j = 0; j < cur_len; j++)
          load_entry(j, ($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom)),
                     $urandom_range(0, 3) == 0, 1'($urandom));
        nreg = (cur_len > 16) ? $urandom_range(1, 2) : $urandom_range(2, 5);
        for (int k = 0; k < nreg; k++) begin
          if (cur_len > 16)
            scan_region($urandom_range(cur_len - 4, cur_len + 20), $urandom_range(0, 2),
                        1'($urandom), 1'b0);
          else
            scan_region($urandom_range(1, cur_len + 10), $urandom_range(0, 2),
                        1'($urandom), $urandom_range(0, 7) == 0);
        end
      end
      phase_no++;
    end

    settle();
    $display("Covered %0d loads and %0d scan bytes over %0d random phases;",
             loads_sent, scans_sent, phase_no);
    $display("%0d region reports checked, %0d with a single hit, %0d saturated.",
             reports, single_hits, saturated);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ wildcard_byte_pattern_scanner_core.f @@
rtl/wbps_pkg.sv
rtl/wbps_cell.sv
rtl/wbps_tally.sv
rtl/wildcard_byte_pattern_scanner_core.sv
test/wbps_checker.sv
test/testbench.sv
